/* rtl/ett_pkg.sv */
// Package for the event timer table: command and result codes, clock
// constants and the controller/datapath command and status structs. No dependencies.
package ett_pkg;

  localparam int unsigned MsPerSec = 1000;
  localparam logic [9:0] MsMax = 10'd999;
  localparam int unsigned ResultCap = 16;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_CREATE = 3'd1,
    KIND_UPDATE = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_QUERY  = 3'd4,
    KIND_SETCLK = 3'd5,
    KIND_RDCLK  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    RK_FIRE  = 3'd0,
    RK_CLEAR = 3'd1,
    RK_QUERY = 3'd2,
    RK_CLOCK = 3'd3,
    RK_FULL  = 3'd4
  } rkind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted input word
    logic scan_clr;   // restart the table scan
    logic scan_step;  // examine one entry and advance
    logic finish;     // apply the decision made by the lookup scan
    logic emit_fire;  // present a fire word for the current entry
    logic emit_final; // present the closing word of a command
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;   // the current entry is the last one
    logic fire_hit;    // the current entry expires on this tick
    logic final_word;  // the command closes with a result word
    logic out_busy;    // the output register holds an untaken word
  } ctl_sts_t;

endpackage

/* rtl/ett_if.sv */
// Valid/ready channel interface for the event timer table.
// Depends on nothing; the payload width is a parameter.
interface ett_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/ett_ctrl.sv */
// Controller of the event timer table: sequences one command at a time.
// Depends on ett_pkg.
module ett_ctrl
  import ett_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output ctl_cmd_t cmd_o,
  input  ctl_sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // A fire word waits here until the output register is free.
        if (!(sts_i.fire_hit && sts_i.out_busy)) begin
          cmd_o.scan_step = 1'b1;
          cmd_o.emit_fire = sts_i.fire_hit;
          if (sts_i.scan_done) state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_FINAL;
      end
      ST_FINAL: begin
        if (!sts_i.final_word) begin
          state_d = ST_IDLE;
        end else if (!sts_i.out_busy) begin
          cmd_o.emit_final = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/ett_dp.sv */
// Datapath of the event timer table: entry registers, clock, scan index
// and output register. Depends on ett_pkg.
module ett_dp
  import ett_pkg::*;
#(
  parameter int unsigned TimerCount = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_cmd_t    cmd_i,
  output ctl_sts_t    sts_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  task_id_i,
  input  logic [7:0]  evt_id_i,
  input  logic [31:0] timeout_i,
  input  logic [7:0]  elapsed_i,
  input  logic [31:0] sec_value_i,
  input  logic [9:0]  ms_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  task_out_o,
  output logic [7:0]  event_out_o,
  output logic [31:0] remaining_o,
  output logic [31:0] sec_out_o,
  output logic [9:0]  ms_out_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (TimerCount > 1) ? $clog2(TimerCount) : 1;
  localparam int unsigned CapW = $clog2(ResultCap + 1);

  logic [31:0] rem_q [TimerCount];
  logic [7:0]  tsk_q [TimerCount];
  logic [7:0]  evt_q [TimerCount];

  logic [2:0]  kind_q;
  logic [7:0]  task_q, event_q, el_q;
  logic [31:0] tmo_q, sec_q, sv_q;
  logic [9:0]  ms_q, mv_q;
  logic [IdxW-1:0] idx_q;
  logic        match_q, free_q;
  logic [IdxW-1:0] match_idx_q, free_idx_q;
  logic [CapW-1:0] nfire_q;

  logic        oval_q;
  logic [2:0]  okind_q;
  logic [7:0]  otask_q, oevt_q;
  logic [31:0] orem_q, osec_q;
  logic [9:0]  oms_q;
  logic        olast_q;

  // Examine the current entry.
  logic [31:0] cur_rem, dec_rem;
  logic        cur_act, cur_match, is_tick, cur_fire, more_fire;
  logic [IdxW-1:0] j;
  assign cur_rem   = rem_q[idx_q];
  assign cur_act   = (cur_rem != 32'd0);
  assign cur_match = cur_act && (tsk_q[idx_q] == task_q) && (evt_q[idx_q] == event_q);
  assign is_tick   = (kind_q == KIND_TICK) && (el_q != 8'd0);
  assign dec_rem   = (cur_rem >= {24'd0, el_q}) ? cur_rem - {24'd0, el_q} : 32'd0;
  assign cur_fire  = is_tick && cur_act && (dec_rem == 32'd0) &&
                     (nfire_q < CapW'(ResultCap));

  // Does a later fire word of this tick follow the current one?
  always_comb begin
    logic [31:0] r;
    more_fire = 1'b0;
    for (int unsigned k = 0; k < TimerCount; k++) begin
      j = IdxW'(k);
      r = rem_q[k];
      if (j > idx_q && r != 32'd0 && r <= {24'd0, el_q}) more_fire = 1'b1;
    end
    if (nfire_q + CapW'(1) >= CapW'(ResultCap)) more_fire = 1'b0;
  end

  logic fin_word;
  always_comb begin
    case (kind_q)
      KIND_CREATE: fin_word = !match_q && (tmo_q != 32'd0) && !free_q;
      KIND_DELETE: fin_word = !match_q;
      KIND_QUERY:  fin_word = 1'b1;
      KIND_RDCLK:  fin_word = 1'b1;
      default:     fin_word = 1'b0;
    endcase
  end

  assign sts_o.scan_done  = (idx_q == IdxW'(TimerCount - 1));
  assign sts_o.fire_hit   = cur_fire;
  assign sts_o.final_word = fin_word;
  assign sts_o.out_busy   = oval_q && !out_ready_i;

  // Captured command and scan bookkeeping.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      task_q  <= task_id_i;
      event_q <= evt_id_i;
      tmo_q   <= timeout_i;
      el_q    <= elapsed_i;
      sv_q    <= sec_value_i;
      mv_q    <= ms_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      match_idx_q <= '0;
      free_idx_q  <= '0;
      nfire_q     <= '0;
    end else if (cmd_i.scan_clr) begin
      idx_q   <= '0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
      nfire_q <= '0;
    end else if (cmd_i.scan_step) begin
      if (!sts_o.scan_done) idx_q <= idx_q + IdxW'(1);
      if (cur_match && !match_q) begin
        match_q     <= 1'b1;
        match_idx_q <= idx_q;
      end
      if (!cur_act && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= idx_q;
      end
      if (cur_fire) nfire_q <= nfire_q + CapW'(1);
    end
  end

  // Table entries: one decremented per scan step of a tick, one written on finish.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < TimerCount; k++) begin
        rem_q[k] <= '0;
        tsk_q[k] <= '0;
        evt_q[k] <= '0;
      end
    end else if (cmd_i.scan_step && is_tick) begin
      rem_q[idx_q] <= dec_rem;
    end else if (cmd_i.finish) begin
      case (kind_q)
        KIND_CREATE: begin
          if (match_q) begin
            rem_q[match_idx_q] <= tmo_q;
          end else if (tmo_q != 32'd0 && free_q) begin
            rem_q[free_idx_q] <= tmo_q;
            tsk_q[free_idx_q] <= task_q;
            evt_q[free_idx_q] <= event_q;
          end
        end
        KIND_UPDATE: if (match_q) rem_q[match_idx_q] <= tmo_q;
        KIND_DELETE: if (match_q) rem_q[match_idx_q] <= 32'd0;
        default: ;
      endcase
    end
  end

  // Seconds and milliseconds clock.
  logic [10:0] ms_sum;
  assign ms_sum = {1'b0, ms_q} + {3'd0, el_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q <= '0;
      ms_q  <= '0;
    end else if (cmd_i.finish) begin
      if (is_tick) begin
        if (ms_sum >= 11'(MsPerSec)) begin
          ms_q  <= 10'(ms_sum - 11'(MsPerSec));
          sec_q <= sec_q + 32'd1;
        end else begin
          ms_q <= ms_sum[9:0];
        end
      end else if (kind_q == KIND_SETCLK) begin
        sec_q <= sv_q;
        ms_q  <= (mv_q > MsMax) ? MsMax : mv_q;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (cmd_i.emit_fire || cmd_i.emit_final) begin
      oval_q <= 1'b1;
    end else if (out_ready_i) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_fire) begin
      okind_q <= RK_FIRE;
      otask_q <= tsk_q[idx_q];
      oevt_q  <= evt_q[idx_q];
      orem_q  <= '0;
      osec_q  <= '0;
      oms_q   <= '0;
      olast_q <= !more_fire;
    end else if (cmd_i.emit_final) begin
      olast_q <= 1'b1;
      orem_q  <= '0;
      osec_q  <= '0;
      oms_q   <= '0;
      otask_q <= task_q;
      oevt_q  <= event_q;
      case (kind_q)
        KIND_CREATE: okind_q <= RK_FULL;
        KIND_DELETE: okind_q <= RK_CLEAR;
        KIND_QUERY: begin
          okind_q <= RK_QUERY;
          orem_q  <= match_q ? rem_q[match_idx_q] : 32'd0;
        end
        default: begin
          okind_q <= RK_CLOCK;
          otask_q <= '0;
          oevt_q  <= '0;
          osec_q  <= sec_q;
          oms_q   <= ms_q;
        end
      endcase
    end
  end

  assign out_valid_o   = oval_q;
  assign result_kind_o = okind_q;
  assign task_out_o    = otask_q;
  assign event_out_o   = oevt_q;
  assign remaining_o   = orem_q;
  assign sec_out_o     = osec_q;
  assign ms_out_o      = oms_q;
  assign last_o        = olast_q;

endmodule

/* rtl/event_timer_table_top.sv */
// Event timer table: a table of one-shot timers named by task and event ids
// and a seconds/milliseconds clock.
//
// Channels: in_if carries command words {kind, task_id, evt_id, timeout,
// elapsed, sec_value, ms_value}; out_if carries result words {result_kind,
// task_out, event_out, remaining, sec_out, ms_out, last}. Both use
// valid/ready, a word moving when both are high.
// Throughput: one command at a time. Each command scans the table one entry
// per cycle while no fire word waits on the output register, then applies
// its decision and closes before the next command is accepted.
// Latency: a fire word appears the cycle after its entry is scanned; a
// query, clock, clear or full word is registered from the final state, after
// the apply step. The final word of each command has last set.
// Reset clears all timers (inactive), the clock and the output register.
// When the receiver stalls, the scan holds at the next firing entry until
// the output register is taken; no word is lost.
module event_timer_table_top
  import ett_pkg::*;
#(
  parameter int unsigned TimerCount = 16
) (
  input logic clk_i,
  input logic rst_ni,
  ett_if.sink   in_if,
  ett_if.source out_if
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ett_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .in_ready_o(in_if.ready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  ett_dp #(.TimerCount(TimerCount)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (in_if.data[100:98]),
    .task_id_i    (in_if.data[97:90]),
    .evt_id_i     (in_if.data[89:82]),
    .timeout_i    (in_if.data[81:50]),
    .elapsed_i    (in_if.data[49:42]),
    .sec_value_i  (in_if.data[41:10]),
    .ms_value_i   (in_if.data[9:0]),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .result_kind_o(out_if.data[93:91]),
    .task_out_o   (out_if.data[90:83]),
    .event_out_o  (out_if.data[82:75]),
    .remaining_o  (out_if.data[74:43]),
    .sec_out_o    (out_if.data[42:11]),
    .ms_out_o     (out_if.data[10:1]),
    .last_o       (out_if.data[0])
  );

endmodule

/* rtl/ett_checker.sv */
// Port-level checks for the event timer table, bound to the top level.
// Depends on ett_pkg.
module ett_checker
  import ett_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [93:0]  out_data
);

  // A result word is never a kind outside the result codes.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data[93:91] <= RK_FULL) else $error("bad result kind");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("word dropped");

  // The block takes no new command the cycle after accepting one.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("overlapping commands");

  // Clock replies carry no ids.
  a_clk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data[93:91] == RK_CLOCK |-> out_data[90:75] == 16'd0)
    else $error("clock reply with ids");

endmodule

bind event_timer_table_top ett_checker u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_data (out_if.data)
);

/* bench/tb_event_timer_table_top.sv */
// Testbench for event_timer_table_top: drives command words and checks every
// result word against a behavioral predictor kept inside the bench.
// Depends on ett_pkg and ett_if from the RTL.
module tb_event_timer_table_top;
  import ett_pkg::*;

  localparam int unsigned TimerCount = 16;
  localparam int unsigned InW = 101;
  localparam int unsigned OutW = 94;
  localparam logic [2:0] KindUnused = 3'd7;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned TailCycles = 2 * (TimerCount + 3);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  task_id;
    logic [7:0]  evt_id;
    logic [31:0] timeout;
    logic [7:0]  elapsed;
    logic [31:0] sec_value;
    logic [9:0]  ms_value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  task_out;
    logic [7:0]  event_out;
    logic [31:0] remaining;
    logic [31:0] sec_out;
    logic [9:0]  ms_out;
    logic        last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ett_if #(.W(InW)) in_if ();
  ett_if #(.W(OutW)) out_if ();

  event_timer_table_top #(.TimerCount(TimerCount)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if),
    .out_if(out_if)
  );

  always #1 clk_i = ~clk_i;

  // Predicted timer table and clock.
  logic [31:0] tmr_left [TimerCount];
  logic [7:0]  tmr_task [TimerCount];
  logic [7:0]  tmr_event [TimerCount];
  logic [31:0] clk_sec;
  logic [9:0]  clk_ms;

  res_t result_q[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_cycles = 0;
  int   quiet_cycles = 0;

  function automatic res_t mk_res(rkind_e k, logic [7:0] t, logic [7:0] e,
                                  logic [31:0] rem, logic [31:0] s, logic [9:0] m);
    res_t r;
    r.result_kind = k;
    r.task_out = t;
    r.event_out = e;
    r.remaining = rem;
    r.sec_out = s;
    r.ms_out = m;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic int find_timer(logic [7:0] t, logic [7:0] e);
    for (int i = 0; i < TimerCount; i++) begin
      if (tmr_left[i] != 0 && tmr_task[i] == t && tmr_event[i] == e) return i;
    end
    return -1;
  endfunction

  // Apply one accepted command to the predicted state and queue its results.
  task automatic apply_cmd(cmd_t c);
    int n;
    int idx;
    logic [10:0] ms_sum;
    n = 0;
    idx = find_timer(c.task_id, c.evt_id);
    case (c.kind)
      KIND_TICK: begin
        if (c.elapsed != 0) begin
          ms_sum = clk_ms + c.elapsed;
          if (ms_sum >= MsPerSec) begin
            ms_sum = ms_sum - 11'(MsPerSec);
            clk_sec = clk_sec + 1;
          end
          clk_ms = ms_sum[9:0];
          for (int i = 0; i < TimerCount; i++) begin
            if (tmr_left[i] != 0) begin
              tmr_left[i] = (tmr_left[i] >= c.elapsed) ? tmr_left[i] - c.elapsed : 0;
              if (tmr_left[i] == 0 && n < ResultCap) begin
                result_q.push_back(mk_res(RK_FIRE, tmr_task[i], tmr_event[i], 0, 0, 0));
                n++;
              end
            end
          end
        end
      end
      KIND_CREATE: begin
        if (idx >= 0) begin
          tmr_left[idx] = c.timeout;
        end else if (c.timeout != 0) begin
          for (int i = TimerCount - 1; i >= 0; i--) begin
            if (tmr_left[i] == 0) idx = i;
          end
          if (idx >= 0) begin
            tmr_left[idx] = c.timeout;
            tmr_task[idx] = c.task_id;
            tmr_event[idx] = c.evt_id;
          end else begin
            result_q.push_back(mk_res(RK_FULL, c.task_id, c.evt_id, 0, 0, 0));
            n++;
          end
        end
      end
      KIND_UPDATE: begin
        if (idx >= 0) tmr_left[idx] = c.timeout;
      end
      KIND_DELETE: begin
        if (idx >= 0) begin
          tmr_left[idx] = 0;
        end else begin
          result_q.push_back(mk_res(RK_CLEAR, c.task_id, c.evt_id, 0, 0, 0));
          n++;
        end
      end
      KIND_QUERY: begin
        result_q.push_back(mk_res(RK_QUERY, c.task_id, c.evt_id,
                                  (idx >= 0) ? tmr_left[idx] : 32'd0, 0, 0));
        n++;
      end
      KIND_SETCLK: begin
        clk_sec = c.sec_value;
        clk_ms = (c.ms_value > MsMax) ? MsMax : c.ms_value;
      end
      KIND_RDCLK: begin
        result_q.push_back(mk_res(RK_CLOCK, 0, 0, 0, clk_sec, clk_ms));
        n++;
      end
      default: begin
      end
    endcase
    if (n > 0) result_q[$].last = 1'b1;
  endtask

  // Offer one command word, idling at random first, and wait for acceptance.
  task automatic send_cmd(cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= c;
    do @(posedge clk_i); while (!in_if.ready);
    apply_cmd(c);
  endtask

  task automatic send_fields(logic [2:0] k, logic [7:0] t, logic [7:0] e,
                             logic [31:0] tmo, logic [7:0] el,
                             logic [31:0] sv, logic [9:0] mv);
    cmd_t c;
    c = '{k, t, e, tmo, el, sv, mv};
    send_cmd(c);
  endtask

  // Stop offering words and wait until every predicted result is in.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random or long stalls, and a field-by-field check of each word.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (result_q.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (got.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
          errors++;
        end
        if (got.task_out !== want.task_out) begin
          $error("task_out: expected %0d, got %0d", want.task_out, got.task_out);
          errors++;
        end
        if (got.event_out !== want.event_out) begin
          $error("event_out: expected %0d, got %0d", want.event_out, got.event_out);
          errors++;
        end
        if (got.remaining !== want.remaining) begin
          $error("remaining: expected %0d, got %0d", want.remaining, got.remaining);
          errors++;
        end
        if (got.sec_out !== want.sec_out) begin
          $error("sec_out: expected %0d, got %0d", want.sec_out, got.sec_out);
          errors++;
        end
        if (got.ms_out !== want.ms_out) begin
          $error("ms_out: expected %0d, got %0d", want.ms_out, got.ms_out);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Clock: saturated set, read, millisecond rollover and seconds wrap.
  task automatic test_clock();
    send_fields(KIND_RDCLK, 0, 0, 0, 0, 0, 0);
    send_fields(KIND_SETCLK, 0, 0, 0, 0, 32'hFFFF_FFFF, 10'h3FF);
    send_fields(KIND_RDCLK, 8'hFF, 8'hFF, 0, 0, 0, 0);
    send_fields(KIND_TICK, 0, 0, 0, 8'd0, 0, 0);
    send_fields(KIND_TICK, 0, 0, 0, 8'hFF, 0, 0);
    send_fields(KIND_RDCLK, 0, 0, 0, 0, 0, 0);
    send_fields(KIND_SETCLK, 0, 0, 0, 0, 32'd5, 10'd998);
    send_fields(KIND_TICK, 0, 0, 0, 8'd1, 0, 0);
    send_fields(KIND_TICK, 0, 0, 0, 8'd1, 0, 0);
    send_fields(KIND_RDCLK, 0, 0, 0, 0, 0, 0);
    send_fields(KindUnused, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 10'h3FF);
    drain();
  endtask

  // Single timers: create, query, update, zero timeout, absent ids, expiry.
  task automatic test_timer_ops();
    send_fields(KIND_CREATE, 8'd0, 8'd0, 32'd0, 0, 0, 0);
    send_fields(KIND_CREATE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0);
    send_fields(KIND_QUERY, 8'hFF, 8'hFF, 0, 0, 0, 0);
    send_fields(KIND_UPDATE, 8'hFF, 8'hFF, 32'd3, 0, 0, 0);
    send_fields(KIND_UPDATE, 8'd1, 8'd1, 32'd9, 0, 0, 0);
    send_fields(KIND_CREATE, 8'd0, 8'd0, 32'd300, 0, 0, 0);
    send_fields(KIND_CREATE, 8'd0, 8'd0, 32'd0, 0, 0, 0);
    send_fields(KIND_QUERY, 8'd0, 8'd0, 0, 0, 0, 0);
    send_fields(KIND_DELETE, 8'd7, 8'd7, 0, 0, 0, 0);
    send_fields(KIND_TICK, 0, 0, 0, 8'd5, 0, 0);
    send_fields(KIND_UPDATE, 8'hFF, 8'hFF, 32'd0, 0, 0, 0);
    send_fields(KIND_DELETE, 8'hFF, 8'hFF, 0, 0, 0, 0);
    drain();
  endtask

  // Fill the table, refuse one more, then expire all sixteen in one tick.
  task automatic test_full_table();
    for (int i = 0; i < TimerCount; i++) begin
      send_fields(KIND_CREATE, 8'(i), 8'(255 - i), 32'(1 + i), 0, 0, 0);
    end
    send_fields(KIND_CREATE, 8'd200, 8'd201, 32'd10, 0, 0, 0);
    send_fields(KIND_TICK, 0, 0, 0, 8'd200, 0, 0);
    drain();
  endtask

  // Random command mix over a small id pool, so lookups hit often.
  task automatic test_random(int count, bit with_hold);
    cmd_t c;
    int r;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_cycles = 300;
      r = $urandom_range(99);
      c.task_id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      c.evt_id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      c.timeout = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(600));
      c.elapsed = 8'($urandom);
      c.sec_value = $urandom;
      c.ms_value = 10'($urandom);
      if (r < 30) c.kind = KIND_TICK;
      else if (r < 55) c.kind = KIND_CREATE;
      else if (r < 63) c.kind = KIND_UPDATE;
      else if (r < 73) c.kind = KIND_DELETE;
      else if (r < 88) c.kind = KIND_QUERY;
      else if (r < 92) c.kind = KIND_SETCLK;
      else if (r < 98) c.kind = KIND_RDCLK;
      else c.kind = KindUnused;
      send_cmd(c);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < TimerCount; i++) begin
      tmr_left[i] = 0;
      tmr_task[i] = 0;
      tmr_event[i] = 0;
    end
    clk_sec = 0;
    clk_ms = 0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 24;
    recv_idle_pct = 47;
    test_clock();
    test_timer_ops();
    test_full_table();
    test_random(90, 1'b1);

    send_idle_pct = 47;
    recv_idle_pct = 24;
    test_random(90, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(90, 1'b1);

    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* event_timer_table_top.f */
rtl/ett_pkg.sv
rtl/ett_if.sv
rtl/ett_ctrl.sv
rtl/ett_dp.sv
rtl/event_timer_table_top.sv
rtl/ett_checker.sv
bench/tb_event_timer_table_top.sv
